// ===== design/cmmd_pkg.sv =====
`default_nettype none

package cmmd_pkg;

    // Default sizes of the copy engine and of the boot image.
    localparam int DMA_LENGTH_DEF = 160;
    localparam int BOOT_SIZE_DEF  = 256;

    // Storage geometry.
    localparam int MAIN_DEPTH = 65536;
    localparam int BOOT_DEPTH = 256;

    // Access codes carried on the action field.
    localparam logic [2:0] ACT_READ      = 3'd0;
    localparam logic [2:0] ACT_WRITE     = 3'd1;
    localparam logic [2:0] ACT_BACKDOOR  = 3'd2;
    localparam logic [2:0] ACT_BOOT_LOAD = 3'd3;
    localparam logic [2:0] ACT_INIT      = 3'd4;

    // Special addresses of the map.
    localparam logic [15:0] ADDR_WRITABLE = 16'h8000;
    localparam logic [15:0] ADDR_LY       = 16'hFF44;
    localparam logic [15:0] ADDR_DIV      = 16'hFF04;
    localparam logic [15:0] ADDR_JOYPAD   = 16'hFF00;
    localparam logic [15:0] ADDR_DMA      = 16'hFF46;
    localparam logic [15:0] ADDR_OAM      = 16'hFE00;
    localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
    localparam logic [15:0] OVERLAY_END   = 16'h0100;
    localparam logic [15:0] ADDR_LCDC     = 16'hFF40;
    localparam logic [15:0] ADDR_BGP      = 16'hFF47;

    // Register values written by the post-boot init.
    localparam logic [7:0] LCDC_INIT = 8'h91;
    localparam logic [7:0] BGP_INIT  = 8'hFC;

    // Port requests toward the main store and the boot store.
    typedef struct packed {
        logic        we;
        logic [15:0] waddr;
        logic [7:0]  wdata;
        logic [15:0] raddr;
    } t_main_req;

    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic [7:0] raddr;
    } t_boot_req;

endpackage

`default_nettype wire

// ===== design/console_memory_map_with_dma_unit.sv =====
`default_nettype none

// Emulated 64 KiB console memory map with boot ROM overlay and OAM copy engine.
//
// Usage: present an access on i_action, i_address, i_data_byte and i_joypad_bits
// and raise start; the access is taken on a clock edge where start is high and
// busy is low. The beat's result appears on the o_ ports and holds there until the
// next access finishes; o_done flags it for exactly one cycle, and the receiver
// cannot stall it.
// The copy loop is run by the sequencer: the main store has a registered read, so
// the copy engine spends one state reading a source byte and the next state
// writing it to OAM, with both addresses coming from one shared adder.
// busy stays high for the whole access, so one access runs at a time; a new
// one can be started in the cycle in which o_done is shown.
// Reset: after i_rst_n is released the block sweeps both stores to zero, one
// address a cycle, with busy high throughout. The overlay and boot-present
// flags reset to zero.

module console_memory_map_with_dma_unit #(
    parameter int DMA_LENGTH = cmmd_pkg::DMA_LENGTH_DEF,
    parameter int BOOT_SIZE  = cmmd_pkg::BOOT_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_joypad_bits,
    output      logic        o_done,
    output      logic [7:0]  o_read_data,
    output      logic        o_joypad_write_valid,
    output      logic [7:0]  o_joypad_write_data,
    output      logic        o_overlay_active,
    output      logic        o_boot_present
);

    import cmmd_pkg::*;

    t_main_req  main_req;
    t_boot_req  boot_req;
    logic [7:0] main_rdata;
    logic [7:0] boot_rdata;

    // The sequencer owns all decode, the flags and the copy loop.
    cmmd_ctrl #(
        .DMA_LENGTH (DMA_LENGTH),
        .BOOT_SIZE  (BOOT_SIZE)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_action       (i_action),
        .i_address      (i_address),
        .i_data_byte    (i_data_byte),
        .i_joypad_bits  (i_joypad_bits),
        .i_main_rdata   (main_rdata),
        .i_boot_rdata   (boot_rdata),
        .o_main_req     (main_req),
        .o_boot_req     (boot_req),
        .o_busy         (busy),
        .o_done         (o_done),
        .o_read_data    (o_read_data),
        .o_joy_valid    (o_joypad_write_valid),
        .o_joy_data     (o_joypad_write_data),
        .o_overlay      (o_overlay_active),
        .o_boot_present (o_boot_present)
    );

    // Full 64 KiB main store.
    cmmd_ram #(
        .WIDTH (8),
        .DEPTH (MAIN_DEPTH)
    ) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (main_req.we),
        .i_waddr (main_req.waddr),
        .i_wdata (main_req.wdata),
        .i_raddr (main_req.raddr),
        .o_rdata (main_rdata)
    );

    // Boot ROM image, always 256 bytes deep; bytes past the image read as zero.
    cmmd_ram #(
        .WIDTH (8),
        .DEPTH (BOOT_DEPTH)
    ) u_boot_ram (
        .i_clk   (i_clk),
        .i_we    (boot_req.we),
        .i_waddr (boot_req.waddr),
        .i_wdata (boot_req.wdata),
        .i_raddr (boot_req.raddr),
        .o_rdata (boot_rdata)
    );

endmodule

`default_nettype wire

// ===== design/cmmd_ram.sv =====
`default_nettype none

module cmmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/cmmd_ctrl.sv =====
`default_nettype none

module cmmd_ctrl #(
    parameter int DMA_LENGTH = cmmd_pkg::DMA_LENGTH_DEF,
    parameter int BOOT_SIZE  = cmmd_pkg::BOOT_SIZE_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [2:0]          i_action,
    input  wire logic [15:0]         i_address,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic [7:0]          i_joypad_bits,
    input  wire logic [7:0]          i_main_rdata,
    input  wire logic [7:0]          i_boot_rdata,
    output      cmmd_pkg::t_main_req o_main_req,
    output      cmmd_pkg::t_boot_req o_boot_req,
    output      logic                o_busy,
    output      logic                o_done,
    output      logic [7:0]          o_read_data,
    output      logic                o_joy_valid,
    output      logic [7:0]          o_joy_data,
    output      logic                o_overlay,
    output      logic                o_boot_present
);

    import cmmd_pkg::*;

    localparam int DCW = $clog2(DMA_LENGTH + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_DMA_RD,
        S_DMA_WR,
        S_DMA_END,
        S_INIT2
    } t_state;

    t_state      r_state, n_state;
    logic [15:0] r_clr, n_clr;
    logic [DCW-1:0] r_cnt, n_cnt;
    logic [2:0]  r_action, n_action;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_data, n_data;
    logic [7:0]  r_joy, n_joy;
    logic        r_overlay, n_overlay;
    logic        r_boot_loaded, n_boot_loaded;
    logic        r_done, n_done;
    logic [7:0]  r_read_data, n_read_data;
    logic        r_joy_valid, n_joy_valid;
    logic [7:0]  r_joy_data, n_joy_data;

    logic        finish;
    logic        joy_hit;
    logic [7:0]  rd_value;
    logic [15:0] op_a;
    logic [15:0] sum;

    // Shared address adder: source walk during reads, OAM walk otherwise.
    assign op_a = (r_state == S_DMA_RD) ? {r_data, 8'h00} : ADDR_OAM;
    assign sum  = op_a + 16'(r_cnt);

    always_comb begin
        if (r_overlay && (r_addr < OVERLAY_END)) begin
            rd_value = i_boot_rdata;
        end else if (r_addr == ADDR_JOYPAD) begin
            rd_value = r_joy;
        end else begin
            rd_value = i_main_rdata;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_cnt         = r_cnt;
        n_action      = r_action;
        n_addr        = r_addr;
        n_data        = r_data;
        n_joy         = r_joy;
        n_overlay     = r_overlay;
        n_boot_loaded = r_boot_loaded;
        n_done        = 1'b0;
        n_read_data   = r_read_data;
        n_joy_valid   = r_joy_valid;
        n_joy_data    = r_joy_data;
        finish        = 1'b0;
        joy_hit       = 1'b0;

        o_main_req       = '0;
        o_main_req.raddr = r_addr;
        o_boot_req       = '0;
        o_boot_req.raddr = r_addr[7:0];

        case (r_state)
            S_CLEAR: begin
                o_main_req.we    = 1'b1;
                o_main_req.waddr = r_clr;
                o_boot_req.we    = (r_clr[15:8] == 8'h00);
                o_boot_req.waddr = r_clr[7:0];
                n_clr            = r_clr + 16'd1;
                if (r_clr == 16'hFFFF) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_action = i_action;
                    n_addr   = i_address;
                    n_data   = i_data_byte;
                    n_joy    = i_joypad_bits;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_action)
                    ACT_READ: begin
                        n_state = S_RD_WAIT;
                    end
                    ACT_WRITE: begin
                        if (r_addr < ADDR_WRITABLE) begin
                            finish = 1'b1;
                        end else if ((r_addr == ADDR_LY) || (r_addr == ADDR_DIV)) begin
                            o_main_req.we    = 1'b1;
                            o_main_req.waddr = r_addr;
                            o_main_req.wdata = 8'h00;
                            finish           = 1'b1;
                        end else if (r_addr == ADDR_JOYPAD) begin
                            joy_hit = 1'b1;
                            finish  = 1'b1;
                        end else if (r_addr == ADDR_DMA) begin
                            n_cnt   = '0;
                            n_state = S_DMA_RD;
                        end else begin
                            if (r_addr == ADDR_BOOT_OFF) begin
                                n_overlay = 1'b0;
                            end
                            o_main_req.we    = 1'b1;
                            o_main_req.waddr = r_addr;
                            o_main_req.wdata = r_data;
                            finish           = 1'b1;
                        end
                    end
                    ACT_BACKDOOR: begin
                        o_main_req.we    = 1'b1;
                        o_main_req.waddr = r_addr;
                        o_main_req.wdata = r_data;
                        finish           = 1'b1;
                    end
                    ACT_BOOT_LOAD: begin
                        if ({1'b0, r_addr} < 17'(BOOT_SIZE)) begin
                            o_boot_req.we    = 1'b1;
                            o_boot_req.waddr = r_addr[7:0];
                            o_boot_req.wdata = r_data;
                        end
                        if ({1'b0, r_addr} == 17'(BOOT_SIZE - 1)) begin
                            n_boot_loaded = 1'b1;
                            n_overlay     = 1'b1;
                        end
                        finish = 1'b1;
                    end
                    ACT_INIT: begin
                        o_main_req.we    = 1'b1;
                        o_main_req.waddr = ADDR_LCDC;
                        o_main_req.wdata = LCDC_INIT;
                        n_state          = S_INIT2;
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
            end
            S_RD_WAIT: begin
                finish = 1'b1;
            end
            S_DMA_RD: begin
                o_main_req.raddr = sum;
                n_state          = S_DMA_WR;
            end
            S_DMA_WR: begin
                o_main_req.we    = 1'b1;
                o_main_req.waddr = sum;
                o_main_req.wdata = i_main_rdata;
                n_cnt            = r_cnt + DCW'(1);
                if (r_cnt == DCW'(DMA_LENGTH - 1)) begin
                    n_state = S_DMA_END;
                end else begin
                    n_state = S_DMA_RD;
                end
            end
            S_DMA_END: begin
                o_main_req.we    = 1'b1;
                o_main_req.waddr = ADDR_DMA;
                o_main_req.wdata = r_data;
                finish           = 1'b1;
            end
            S_INIT2: begin
                o_main_req.we    = 1'b1;
                o_main_req.waddr = ADDR_BGP;
                o_main_req.wdata = BGP_INIT;
                finish           = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            n_done      = 1'b1;
            n_state     = S_IDLE;
            n_read_data = (r_state == S_RD_WAIT) ? rd_value : 8'h00;
            n_joy_valid = joy_hit;
            n_joy_data  = joy_hit ? r_data : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_cnt         <= '0;
            r_overlay     <= 1'b0;
            r_boot_loaded <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr         <= n_clr;
            r_cnt         <= n_cnt;
            r_overlay     <= n_overlay;
            r_boot_loaded <= n_boot_loaded;
            r_done        <= n_done;
        end
        r_action    <= n_action;
        r_addr      <= n_addr;
        r_data      <= n_data;
        r_joy       <= n_joy;
        r_read_data <= n_read_data;
        r_joy_valid <= n_joy_valid;
        r_joy_data  <= n_joy_data;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_read_data    = r_read_data;
    assign o_joy_valid    = r_joy_valid;
    assign o_joy_data     = r_joy_data;
    assign o_overlay      = r_overlay;
    assign o_boot_present = r_boot_loaded;

    // A result is only shown once the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    // No store is modified while waiting for a new access.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!o_main_req.we && !o_boot_req.we))
        else $error("store written while idle");

    // Copy writes stay inside the object attribute page.
    a_dma_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DMA_WR) |-> (o_main_req.waddr[15:8] == ADDR_OAM[15:8]))
        else $error("copy write left the OAM page");

    // Finishing a boot image always switches the overlay on at the same edge.
    a_boot_overlay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_boot_loaded) |-> r_overlay)
        else $error("boot image loaded without overlay");

    // A result without the joypad strobe carries a zero joypad byte.
    a_joy_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_joy_valid || (r_joy_data == 8'h00)))
        else $error("joypad byte set without strobe");

endmodule

`default_nettype wire
